// File: hdl/crml_pkg.sv
`timescale 1ns / 1ps

package crml_pkg;

  localparam int LUMA_W = 8;
  localparam int MEAN_W = 16;
  localparam int FRAC_W = 8;
  localparam int REG_W = 13;
  localparam int IDX_W = 2;
  localparam int CNT_W = 2 * REG_W;
  localparam int SUM_W = CNT_W + LUMA_W;
  localparam int DIV_W = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DIV_W);

  localparam int DEF_MAX_FRAME_WIDTH = 4096;
  localparam int DEF_MAX_FRAME_HEIGHT = 4096;

  localparam logic [REG_W-1:0] RST_FRAME_WIDTH = REG_W'(640);
  localparam logic [REG_W-1:0] RST_FRAME_HEIGHT = REG_W'(480);
  localparam logic [REG_W-1:0] RST_WINDOW_WIDTH = REG_W'(64);
  localparam logic [REG_W-1:0] RST_WINDOW_HEIGHT = REG_W'(64);

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH = 2'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd3;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_BAD_WINDOW = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_HOLD
  } seq_state_t;

  typedef struct packed {
    logic hit;
    logic frame_end;
    logic win_ok;
  } scan_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/crml_ifs.sv
`timescale 1ns / 1ps

interface crml_pix_if import crml_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] luma;

  modport source (output valid, output luma, input ready);
  modport sink (input valid, input luma, output ready);
endinterface

interface crml_res_if import crml_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_luma;
  logic              status;

  modport source (output valid, output mean_luma, output status, input ready);
  modport sink (input valid, input mean_luma, input status, output ready);
endinterface

// File: hdl/crml_scan.sv
`timescale 1ns / 1ps

module crml_scan import crml_pkg::*; #(
  parameter int MAX_FRAME_WIDTH = DEF_MAX_FRAME_WIDTH,
  parameter int MAX_FRAME_HEIGHT = DEF_MAX_FRAME_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [REG_W-1:0] frame_width,
  input  logic [REG_W-1:0] frame_height,
  input  logic [REG_W-1:0] window_width,
  input  logic [REG_W-1:0] window_height,
  output scan_t            info
);

  localparam int PCW = $clog2(MAX_FRAME_WIDTH);
  localparam int PRW = $clog2(MAX_FRAME_HEIGHT);
  localparam int DWW = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int DHW = $clog2(MAX_FRAME_HEIGHT + 1);
  localparam int XA = (DWW > DHW) ? DWW : DHW;
  localparam int XW = ((XA > REG_W) ? XA : REG_W) + 1;

  logic [PCW-1:0] col;
  logic [PRW-1:0] row;

  logic [XW-1:0] fw_raw, fh_raw, fw, fh, ww, wh;
  logic [XW-1:0] col_x, row_x, c0, r0;
  logic          last_col, last_row, win_ok, in_col, in_row;

  always_comb begin
    fw_raw = XW'(frame_width);
    fh_raw = XW'(frame_height);
    ww = XW'(window_width);
    wh = XW'(window_height);
    if (frame_width == '0) begin
      fw = XW'(1);
    end else if (fw_raw > XW'(MAX_FRAME_WIDTH)) begin
      fw = XW'(MAX_FRAME_WIDTH);
    end else begin
      fw = fw_raw;
    end
    if (frame_height == '0) begin
      fh = XW'(1);
    end else if (fh_raw > XW'(MAX_FRAME_HEIGHT)) begin
      fh = XW'(MAX_FRAME_HEIGHT);
    end else begin
      fh = fh_raw;
    end
    col_x = XW'(col);
    row_x = XW'(row);
    last_col = (col_x + XW'(1)) >= fw;
    last_row = (row_x + XW'(1)) >= fh;
    win_ok = (ww != '0) && (wh != '0) && (ww <= fw) && (wh <= fh);
    c0 = (fw - ww) >> 1;
    r0 = (fh - wh) >> 1;
    in_col = (col_x >= c0) && (col_x < c0 + ww);
    in_row = (row_x >= r0) && (row_x < r0 + wh);
    info.hit = win_ok && in_col && in_row;
    info.frame_end = last_col && last_row;
    info.win_ok = win_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row <= '0;
        end else begin
          row <= row + PRW'(1);
        end
      end else begin
        col <= col + PCW'(1);
      end
    end
  end

endmodule

// File: hdl/crml_div.sv
`timescale 1ns / 1ps

module crml_div import crml_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  input  logic [CNT_W-1:0]  count,
  output logic [MEAN_W-1:0] quotient,
  output div_stat_t         stat
);

  logic [CNT_W-1:0]  rem;
  logic [DIV_W-1:0]  lo;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;
  logic [CNT_W-1:0] rem_next;

  // one restoring step per cycle, remainder stays below the divisor
  always_comb begin
    trial = {rem, lo[DIV_W-1]};
    ge = trial >= {1'b0, count};
    diff = trial - {1'b0, count};
    rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= STEP_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // full quotient bits shift through, only the low MEAN_W bits are kept
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      lo <= {sum, {FRAC_W{1'b0}}};
    end else if (busy) begin
      rem <= rem_next;
      lo <= lo << 1;
      quotient <= {quotient[MEAN_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(DIV_W + 1) done)
    else $error("divider did not finish in the expected number of steps");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

endmodule

// File: hdl/center_roi_mean_luma.sv
`timescale 1ns / 1ps

// Mean luma of a window centered in the frame.
// pixel: one luma byte per transfer, raster order. The block counts columns
// and rows itself and wraps at frame_width x frame_height (clamped to 1 and
// to MAX_FRAME_WIDTH / MAX_FRAME_HEIGHT).
// result: one transfer per frame, after its last pixel: mean_luma is the
// window mean as unsigned 8.8, truncated; status 1 flags an empty or
// oversized window, with mean_luma 0.
// Config: wr_en / wr_index / wr_data write frame_width, frame_height,
// window_width, window_height (index 0..3); write only while idle.
// Throughput: one pixel per cycle except the last pixel of a frame, which
// holds pixel.ready low through a multiply state for the window area, a
// load state, the restoring divider (42 quotient bits, one per cycle, and a
// finishing step) and a handoff state, which also waits while a stalled
// result holds the output register. An empty or oversized window skips the
// division and goes straight to the handoff state.
// Reset: registers return to 640x480 with a 64x64 window, position and sum
// clear, no result pending. A stalled result sits in the output register;
// pixels keep flowing until the next frame's result needs that register.
module center_roi_mean_luma import crml_pkg::*; #(
  parameter int MAX_FRAME_WIDTH = DEF_MAX_FRAME_WIDTH,
  parameter int MAX_FRAME_HEIGHT = DEF_MAX_FRAME_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0] wr_data,
  crml_pix_if.sink         pixel,
  crml_res_if.source       result
);

  logic [REG_W-1:0] frame_width, frame_height, window_width, window_height;

  seq_state_t state, state_next;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_hit;
  logic [SUM_W-1:0]  sum_final;
  logic [CNT_W-1:0]  count;
  logic              bad_win;
  logic              res_valid;
  logic [MEAN_W-1:0] res_mean;
  logic              res_status;

  logic              take;
  logic              load_res;
  logic              div_start;
  logic [MEAN_W-1:0] quotient;
  div_stat_t         stat;
  scan_t             info;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      window_width <= RST_WINDOW_WIDTH;
      window_height <= RST_WINDOW_HEIGHT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FRAME_WIDTH:   frame_width <= wr_data;
        REG_FRAME_HEIGHT:  frame_height <= wr_data;
        REG_WINDOW_WIDTH:  window_width <= wr_data;
        REG_WINDOW_HEIGHT: window_height <= wr_data;
        default: ;
      endcase
    end
  end

  crml_scan #(
    .MAX_FRAME_WIDTH(MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .step(take),
    .frame_width(frame_width),
    .frame_height(frame_height),
    .window_width(window_width),
    .window_height(window_height),
    .info(info)
  );

  crml_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .sum(sum_final),
    .count(count),
    .quotient(quotient),
    .stat(stat)
  );

  assign pixel.ready = (state == S_IDLE);
  assign take = pixel.valid && pixel.ready;
  assign sum_hit = info.hit ? sum + SUM_W'(pixel.luma) : sum;

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    load_res = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take && info.frame_end) begin
          state_next = info.win_ok ? S_MUL : S_HOLD;
        end
      end
      S_MUL: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.done) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!res_valid || result.ready) begin
          load_res = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sum <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        sum <= info.frame_end ? '0 : sum_hit;
      end
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && info.frame_end) begin
      sum_final <= sum_hit;
      bad_win <= !info.win_ok;
    end
    if (state == S_MUL) begin
      count <= CNT_W'(window_width) * CNT_W'(window_height);
    end
    if (load_res) begin
      res_mean <= bad_win ? '0 : quotient;
      res_status <= bad_win ? STATUS_BAD_WINDOW : STATUS_OK;
    end
  end

  assign result.valid = res_valid;
  assign result.mean_luma = res_mean;
  assign result.status = res_status;

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pixel.ready)
    else $error("pixel taken while a frame result is in progress");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status == STATUS_BAD_WINDOW)) |-> (result.mean_luma == '0))
    else $error("bad window result carries a nonzero mean");

endmodule
